>>> rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define FRSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define FRSP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/frsp_pkg.sv
`default_nettype none

package frsp_pkg;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned OUT_W   = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned MODE_W  = 2;

    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEQ    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUAL   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

    localparam logic [MODE_W-1:0] MODE_SEQ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ENC  = 2'd2;

    localparam logic REG_PARSE_MODE     = 1'b0;
    localparam logic REG_QUALITY_OFFSET = 1'b1;

    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OUT_W-1:0]  value;
        logic              ok;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/fasta_record_stream_parser.sv
// a result goes into the output register, or into the skid entry while output stalls
// throughput: one byte per cycle while s_tready is high; parse is one registered pass
// an output register plus one skid entry keep s_tready up while a result waits
// reset: synchronous, active low; clears phase, number, valid flags, config registers
`default_nettype none

module fasta_record_stream_parser
    import frsp_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wr_en,
    input  wire                 cfg_addr,
    input  wire  [BYTE_W-1:0]   cfg_data,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [BYTE_W-1:0]   s_tdata,   // [7:0] in_byte
    input  wire                 s_tlast,   // end_of_input
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // [15:0] item_value
    output logic [2:0]          m_tuser    // [1:0] item_kind, [2] record_ok
);

    localparam logic [1:0] PH_SEEK   = 2'd0;
    localparam logic [1:0] PH_SPACES = 2'd1;
    localparam logic [1:0] PH_HEADER = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    localparam int unsigned PROD_W = VALUE_WIDTH + 4;

    logic [1:0]             phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   pend_reg, pend_next;
    logic [MODE_W-1:0]      mode_reg;
    logic [BYTE_W-1:0]      offset_reg;

    result_t                out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                skid_reg, skid_next;
    logic                   skid_valid_reg, skid_valid_next;

    logic                   accept;
    logic                   pop;
    logic                   emit;
    result_t                res;
    logic                   is_ws;
    logic                   is_digit;
    logic [PROD_W-1:0]      prod;
    logic [VALUE_WIDTH-1:0] acc_sat;
    logic [OUT_W-1:0]       acc_ext;
    logic [BYTE_W-1:0]      enc_val;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.value;
    assign m_tuser  = {out_reg.ok, out_reg.kind};

    assign is_ws    = (s_tdata == CH_SPACE) || ((s_tdata >= CH_TAB) && (s_tdata <= CH_CR));
    assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);

    // acc * 10 + digit, saturating at all ones
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                + {{(PROD_W-4){1'b0}}, s_tdata[3:0] - CH_ZERO[3:0]};
    assign acc_sat = (prod[PROD_W-1:VALUE_WIDTH] != '0) ? '1 : prod[VALUE_WIDTH-1:0];

    assign acc_ext = OUT_W'(acc_reg);
    assign enc_val = acc_ext[BYTE_W-1:0] + offset_reg;

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        emit       = 1'b0;
        res.kind   = KIND_HEADER;
        res.value  = {{(OUT_W-BYTE_W){1'b0}}, s_tdata};
        res.ok     = 1'b0;
        unique case (phase_reg)
            PH_SEEK: begin
                if (s_tlast) begin
                    emit       = 1'b1;
                    res.kind   = KIND_END;
                    res.value  = '0;
                    acc_next   = '0;
                    pend_next  = 1'b0;
                end else if (s_tdata == CH_GT) begin
                    phase_next = PH_SPACES;
                end
            end
            PH_SPACES: begin
                if (s_tlast) begin
                    emit       = 1'b1;
                    res.kind   = KIND_END;
                    res.value  = '0;
                    acc_next   = '0;
                    pend_next  = 1'b0;
                    phase_next = PH_SEEK;
                end else if (s_tdata == CH_LF) begin
                    phase_next = PH_BODY;
                end else if (s_tdata != CH_SPACE) begin
                    phase_next = PH_HEADER;
                    emit       = 1'b1;
                end
            end
            PH_HEADER: begin
                if (s_tlast) begin
                    emit       = 1'b1;
                    res.kind   = KIND_END;
                    res.value  = '0;
                    res.ok     = 1'b1;
                    acc_next   = '0;
                    pend_next  = 1'b0;
                    phase_next = PH_SEEK;
                end else if (s_tdata == CH_LF) begin
                    phase_next = PH_BODY;
                end else begin
                    emit       = 1'b1;
                end
            end
            PH_BODY: begin
                if (s_tlast || (s_tdata == CH_GT)) begin
                    emit       = 1'b1;
                    res.kind   = KIND_END;
                    res.value  = '0;
                    res.ok     = 1'b1;
                    acc_next   = '0;
                    pend_next  = 1'b0;
                    phase_next = s_tlast ? PH_SEEK : PH_SPACES;
                end else if (mode_reg == MODE_SEQ) begin
                    emit       = !is_ws;
                    res.kind   = KIND_SEQ;
                end else if (is_ws) begin
                    acc_next   = '0;
                    pend_next  = 1'b0;
                    emit       = pend_reg;
                    res.kind   = KIND_QUAL;
                    if (mode_reg >= MODE_ENC) begin
                        res.value = {{(OUT_W-BYTE_W){1'b0}}, enc_val};
                    end else begin
                        res.value = acc_ext;
                    end
                end else if (is_digit) begin
                    acc_next   = acc_sat;
                    pend_next  = 1'b1;
                end
            end
            default: begin
                phase_next = PH_SEEK;
            end
        endcase
    end

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (accept && emit) begin
            if (!out_valid_reg || pop) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SEEK;
            acc_reg        <= '0;
            pend_reg       <= 1'b0;
            mode_reg       <= MODE_SEQ;
            offset_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                pend_reg  <= pend_next;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_PARSE_MODE:     mode_reg   <= cfg_data[MODE_W-1:0];
                    REG_QUALITY_OFFSET: offset_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

>>> rtl/frsp_checker.sv
`default_nettype none

`include "assert_macros.svh"

module frsp_checker
    import frsp_pkg::*;
(
    input wire                aclk,
    input wire                aresetn,
    input wire                s_tvalid,
    input wire                s_tready,
    input wire                s_tlast,
    input wire                m_tvalid,
    input wire                m_tready,
    input wire [OUT_W-1:0]    m_tdata,
    input wire [2:0]          m_tuser
);

    `FRSP_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    `FRSP_ASSERT_IMP(a_ok_only_on_end, aclk, aresetn, m_tvalid && (m_tuser[1:0] != KIND_END),
        !m_tuser[2], "record_ok set on a non record end item")

    `FRSP_ASSERT_IMP(a_end_value_zero, aclk, aresetn, m_tvalid && (m_tuser[1:0] == KIND_END),
        m_tdata == '0, "record end carries a nonzero value")

    `FRSP_ASSERT_IMP(a_byte_range, aclk, aresetn,
        m_tvalid && ((m_tuser[1:0] == KIND_HEADER) || (m_tuser[1:0] == KIND_SEQ)),
        m_tdata[OUT_W-1:BYTE_W] == '0, "header or sequence byte wider than 8 bits")

    `FRSP_ASSERT_NXT(a_eof_ends, aclk, aresetn,
        s_tvalid && s_tready && s_tlast && (!m_tvalid || m_tready),
        m_tvalid && (m_tuser[1:0] == KIND_END), "end of input gave no record end")

endmodule

bind fasta_record_stream_parser frsp_checker u_frsp_checker (.*);

`default_nettype wire

>>> tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import frsp_pkg::*;

    localparam int unsigned VALUE_WIDTH     = 16;
    localparam logic [31:0] VALUE_MAX       = (32'd1 << VALUE_WIDTH) - 32'd1;
    localparam logic [1:0]  MODE_UNUSED     = 2'd3;
    localparam int unsigned ITEMS_PER_PHASE = 72;
    localparam int unsigned N_PHASES        = 8;
    localparam int unsigned N_DIRECTED      = 29;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned HOLD_CYCLES     = 120;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned DRAIN_LIMIT     = 5000;

    typedef enum logic [1:0] {SEEKING, SKIP_SPACES, IN_HEADER, IN_BODY} parse_phase_t;
    typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

    typedef struct packed {
        row_op_t    op;
        logic       reg_sel;
        logic [7:0] data;
        logic       eof;
        logic       fixed;
        logic       any;
        result_t    res;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eof;
    } stim_t;

    localparam result_t NO_RES = '{KIND_HEADER, 16'h0000, 1'b0};

    localparam logic [7:0] BASES [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

    localparam logic [1:0] PHASE_MODE [N_PHASES] =
        '{MODE_SEQ, MODE_QUAL, MODE_ENC, MODE_UNUSED, MODE_QUAL, MODE_ENC, MODE_SEQ, MODE_ENC};
    // -1 draws a random offset
    localparam int PHASE_OFFSET [N_PHASES] = '{0, 0, 255, -1, -1, 0, 255, -1};

    dir_row_t directed_tbl [N_DIRECTED] = '{
        '{ROW_BYTE, REG_PARSE_MODE,     8'h00,    1'b1, 1'b1, 1'b1, '{KIND_END, 16'h0000, 1'b0}},
        '{ROW_BYTE, REG_PARSE_MODE,     8'h78,    1'b0, 1'b1, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_GT,    1'b0, 1'b1, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_SPACE, 1'b0, 1'b1, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     8'h00,    1'b1, 1'b1, 1'b1, '{KIND_END, 16'h0000, 1'b0}},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_GT,    1'b0, 1'b1, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_LF,    1'b0, 1'b1, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     8'hFF,    1'b0, 1'b1, 1'b1, '{KIND_SEQ, 16'h00FF, 1'b0}},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_TAB,   1'b0, 1'b1, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_GT,    1'b0, 1'b1, 1'b1, '{KIND_END, 16'h0000, 1'b1}},
        '{ROW_BYTE, REG_PARSE_MODE,     8'h41,    1'b0, 1'b1, 1'b1, '{KIND_HEADER, 16'h0041, 1'b0}},
        '{ROW_BYTE, REG_PARSE_MODE,     8'h00,    1'b0, 1'b1, 1'b1, '{KIND_HEADER, 16'h0000, 1'b0}},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_LF,    1'b0, 1'b1, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     8'h67,    1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  REG_PARSE_MODE,     8'(MODE_QUAL), 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_NINE,  1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_NINE,  1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_NINE,  1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_NINE,  1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_NINE,  1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_NINE,  1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_CR,    1'b0, 1'b1, 1'b1, '{KIND_QUAL, 16'hFFFF, 1'b0}},
        '{ROW_BYTE, REG_PARSE_MODE,     8'h31,    1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  REG_PARSE_MODE,     8'(MODE_ENC), 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  REG_QUALITY_OFFSET, 8'hFF,    1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_SPACE, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     8'h33,    1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_BYTE, REG_PARSE_MODE,     CH_GT,    1'b0, 1'b1, 1'b1, '{KIND_END, 16'h0000, 1'b1}},
        '{ROW_BYTE, REG_PARSE_MODE,     8'hFF,    1'b1, 1'b1, 1'b1, '{KIND_END, 16'h0000, 1'b0}}
    };

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_addr  = 1'b0;
    logic [BYTE_W-1:0] cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    wire               s_tready;
    logic [BYTE_W-1:0] s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    wire               m_tvalid;
    logic              m_tready  = 1'b0;
    wire  [OUT_W-1:0]  m_tdata;
    wire  [2:0]        m_tuser;

    logic [1:0]   cur_mode   = MODE_SEQ;
    logic [7:0]   cur_offset = '0;
    parse_phase_t cur_phase  = SEEKING;
    logic [31:0]  num_acc    = '0;
    logic         num_pend   = 1'b0;

    result_t     expected_q [$];
    stim_t       stim_q [$];
    int unsigned fail_cnt = 0;
    int unsigned reports  = 0;
    bit          s_idle   = 1'b1;
    int unsigned s_burst  = 0;

    fasta_record_stream_parser #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic [7:0] ws_char();
        int unsigned r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic eof = 1'b0);
        stim_q = {stim_q, stim_t'{b, eof}};
    endfunction

    function automatic void add_expected(input result_t r);
        expected_q = {expected_q, r};
    endfunction

    // one parse step; returns 1 when the byte yields a result
    function automatic bit parse_byte(input logic [7:0] b, input logic eof, output result_t r);
        logic [31:0] n;
        logic [31:0] acc_val;
        logic        had;
        r = NO_RES;
        if (eof) begin
            r.kind    = KIND_END;
            r.ok      = (cur_phase == IN_HEADER) || (cur_phase == IN_BODY);
            cur_phase = SEEKING;
            num_acc   = '0;
            num_pend  = 1'b0;
            return 1'b1;
        end
        case (cur_phase)
            SEEKING: begin
                if (b == CH_GT)
                    cur_phase = SKIP_SPACES;
                return 1'b0;
            end
            SKIP_SPACES: begin
                if (b == CH_SPACE)
                    return 1'b0;
                if (b == CH_LF) begin
                    cur_phase = IN_BODY;
                    return 1'b0;
                end
                cur_phase = IN_HEADER;
                r.value   = 16'(b);
                return 1'b1;
            end
            IN_HEADER: begin
                if (b == CH_LF) begin
                    cur_phase = IN_BODY;
                    return 1'b0;
                end
                r.value = 16'(b);
                return 1'b1;
            end
            default: ;
        endcase
        if (b == CH_GT) begin
            r.kind    = KIND_END;
            r.ok      = 1'b1;
            cur_phase = SKIP_SPACES;
            num_acc   = '0;
            num_pend  = 1'b0;
            return 1'b1;
        end
        if (cur_mode == MODE_SEQ) begin
            if (is_space(b))
                return 1'b0;
            r.kind  = KIND_SEQ;
            r.value = 16'(b);
            return 1'b1;
        end
        if (is_space(b)) begin
            acc_val  = num_acc;
            had      = num_pend;
            num_acc  = '0;
            num_pend = 1'b0;
            if (!had)
                return 1'b0;
            r.kind = KIND_QUAL;
            if (cur_mode == MODE_QUAL)
                r.value = acc_val[15:0];
            else
                r.value = 16'(8'(acc_val[7:0] + cur_offset));
            return 1'b1;
        end
        if (b >= CH_ZERO && b <= CH_NINE) begin
            n        = num_acc * 10 + 32'(b - CH_ZERO);
            num_acc  = (n > VALUE_MAX) ? VALUE_MAX : n;
            num_pend = 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eof, input logic fixed,
                             input logic any, input result_t res);
        int unsigned gap;
        result_t     r;
        bit          got;
        if (s_burst == 0) begin
            s_burst = $urandom_range(5, 40);
            s_idle  = ($urandom_range(0, 2) != 0);
        end
        s_burst--;
        gap = s_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = parse_byte(b, eof, r);
        if (fixed) begin
            if (any)
                add_expected(res);
        end else if (got) begin
            add_expected(r);
        end
    endtask

    task automatic settle_and_write(input logic sel, input logic [7:0] val);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (sel == REG_PARSE_MODE)
            cur_mode = val[1:0];
        else
            cur_offset = val;
    endtask

    // mostly well-formed records with random content, some raw noise
    task automatic build_records(input logic [1:0] mode, input int unsigned count);
        int unsigned n;
        int unsigned r;
        stim_q.delete();
        while (stim_q.size() < count) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
                push_byte(CH_GT);
                repeat ($urandom_range(0, 2)) push_byte(CH_SPACE);
                repeat ($urandom_range(0, 8)) push_byte(8'($urandom_range(33, 126)));
                push_byte(CH_LF);
                if (mode == MODE_SEQ) begin
                    repeat ($urandom_range(1, 12)) begin
                        r = $urandom_range(0, 9);
                        if (r < 6)
                            push_byte(BASES[r % 4]);
                        else if (r < 8)
                            push_byte(ws_char());
                        else
                            push_byte(8'($urandom_range(0, 255)));
                    end
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6)
                                                        : $urandom_range(1, 3);
                        repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                        if ($urandom_range(0, 7) == 0)
                            push_byte(8'($urandom_range(0, 255)));
                        // leaving out the separator lets a pending number get dropped
                        if ($urandom_range(0, 5) != 0)
                            push_byte(ws_char());
                    end
                end
                if ($urandom_range(0, 3) == 0)
                    push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    task automatic check_result();
        result_t want;
        if (expected_q.size() == 0) begin
            fail_cnt++;
            if (reports < MAX_REPORTS) begin
                reports++;
                $display("unexpected result: kind %0d value %0d ok %0d",
                         m_tuser[KIND_W-1:0], m_tdata, m_tuser[KIND_W]);
            end
            return;
        end
        want = expected_q.pop_front();
        if (m_tuser[KIND_W-1:0] !== want.kind || m_tdata !== want.value
                || m_tuser[KIND_W] !== want.ok) begin
            fail_cnt++;
            if (reports < MAX_REPORTS) begin
                reports++;
                $display("mismatch kind/value/ok: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                         want.kind, want.value, want.ok,
                         m_tuser[KIND_W-1:0], m_tdata, m_tuser[KIND_W]);
            end
        end
    endtask

    initial begin : result_sink
        int unsigned gap;
        int unsigned seen;
        int unsigned burst;
        bit          idle;
        seen  = 0;
        burst = 0;
        idle  = 1'b1;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (burst == 0) begin
                burst = $urandom_range(5, 40);
                idle  = ($urandom_range(0, 2) != 0);
            end
            burst--;
            gap = idle ? $urandom_range(0, 10) : 0;
            // long hold-off so the parser backs up and drops s_tready
            if (seen == 150 || seen == 350)
                gap = HOLD_CYCLES;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            check_result();
            seen++;
        end
    end

    initial begin : stimulus
        int unsigned k;
        int unsigned w;
        logic [7:0]  off;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_tbl[i]) begin
            if (directed_tbl[i].op == ROW_CFG)
                settle_and_write(directed_tbl[i].reg_sel, directed_tbl[i].data);
            else
                send_byte(directed_tbl[i].data, directed_tbl[i].eof, directed_tbl[i].fixed,
                          directed_tbl[i].any, directed_tbl[i].res);
        end
        for (k = 0; k < N_PHASES; k++) begin
            off = (PHASE_OFFSET[k] < 0) ? 8'($urandom_range(0, 255)) : 8'(PHASE_OFFSET[k]);
            settle_and_write(REG_PARSE_MODE, 8'(PHASE_MODE[k]));
            settle_and_write(REG_QUALITY_OFFSET, off);
            build_records(PHASE_MODE[k], ITEMS_PER_PHASE);
            foreach (stim_q[j])
                send_byte(stim_q[j].b, stim_q[j].eof, 1'b0, 1'b0, NO_RES);
        end
        s_tvalid <= 1'b0;
        for (w = 0; w < DRAIN_LIMIT && expected_q.size() != 0; w++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (expected_q.size() != 0) begin
            fail_cnt += expected_q.size();
            $display("%0d expected results never arrived", expected_q.size());
        end
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
